@@ hw/rtl/irpm_pkg.sv @@
// shared widths, constants and register codes of the image quality meter
package irpm_pkg;

	localparam int PIXEL_W     = 8;
	localparam int DIM_CFG_W   = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int SUM_W       = 40;
	localparam int SQ_W        = 16;
	localparam int RMSE_W      = 16;
	localparam int PSNR_W      = 15;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// largest dimension the 13-bit registers can hold
	localparam int DIM_REG_MAX = 8191;
	localparam int DIM_RESET   = 256;

	// dividend is the sum shifted up by 18 for the Q8.8 root
	localparam int RMSE_SHIFT = 18;
	localparam int QUO_W      = SUM_W + RMSE_SHIFT;

	// log2 mantissa in Q1.31 and 24 fraction bits
	localparam int MANT_W = 32;
	localparam int FRAC_W = 24;

	localparam int              PEAK_W        = 16;
	localparam logic [PEAK_W-1:0] PEAK_SQUARED = 16'd65025;

	// 10*log10(2)*256 in Q16
	localparam int                   PSNR_SCALE_W = 26;
	localparam logic [PSNR_SCALE_W-1:0] PSNR_SCALE = 26'd50504453;
	localparam int                   PSNR_SHIFT   = 40;

	localparam logic [PSNR_W-1:0] PSNR_MAX = 15'h7FFF;
	localparam logic [RMSE_W-1:0] RMSE_MAX = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;

endpackage

@@ hw/rtl/irpm_pixel_if.sv @@
// pixel pair channel: reference and target pixel at the same position
interface irpm_pixel_if import irpm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PIXEL_W-1:0] reference_pixel;
	logic [PIXEL_W-1:0] target_pixel;

	modport source (output valid, output reference_pixel, output target_pixel, input ready);
	modport sink   (input valid, input reference_pixel, input target_pixel, output ready);
endinterface

@@ hw/rtl/irpm_result_if.sv @@
// per-image result channel: error sum, rmse, psnr and identical flag
interface irpm_result_if import irpm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SUM_W-1:0]  sum_squared_error;
	logic [RMSE_W-1:0] rmse;
	logic [PSNR_W-1:0] psnr;
	logic              images_identical;

	modport source (output valid, output sum_squared_error, output rmse, output psnr,
		output images_identical, input ready);
	modport sink   (input valid, input sum_squared_error, input rmse, input psnr,
		input images_identical, output ready);
endinterface

@@ hw/rtl/irpm_front.sv @@
// front end: config registers, squared error accumulation and end of image detection
module irpm_front import irpm_pkg::*; #(
	parameter int MAX_DIMENSION = 4096,
	parameter int DIM_W         = 13,
	parameter int N_W           = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DIM_CFG_W-1:0] cfg_data,
	irpm_pixel_if.sink           pixel,
	output logic                 push_valid,
	input  logic                 push_ready,
	output logic [SUM_W+N_W-1:0] push_data
);

	localparam int DIM_CAP   = (MAX_DIMENSION > DIM_REG_MAX) ? DIM_REG_MAX : MAX_DIMENSION;
	localparam int RESET_DIM = (DIM_CAP < DIM_RESET) ? DIM_CAP : DIM_RESET;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > DIM_CAP) begin
			r = DIM_W'(DIM_CAP);
		end else begin
			r = v[DIM_W-1:0];
		end
		return r;
	endfunction

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [N_W-1:0]   n_q;
	logic [SUM_W-1:0] acc_q;
	logic [N_W-1:0]   cnt_q;

	logic [DIM_W-1:0]   dim_new;
	logic [PIXEL_W-1:0] abs_diff;
	logic [SQ_W-1:0]    sq;
	logic [SUM_W-1:0]   acc_next;
	logic [N_W-1:0]     cnt_next;
	logic               accept;
	logic               done;

	assign dim_new = clamp_dim(cfg_data);

	// pixel count of the image is kept as a product, refreshed on each width or height write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(RESET_DIM);
			height_q <= DIM_W'(RESET_DIM);
			n_q      <= N_W'(RESET_DIM * RESET_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q <= dim_new;
					n_q     <= N_W'(dim_new) * N_W'(height_q);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= dim_new;
					n_q      <= N_W'(width_q) * N_W'(dim_new);
				end
				default: ;
			endcase
		end
	end

	assign abs_diff = (pixel.reference_pixel >= pixel.target_pixel) ?
		(pixel.reference_pixel - pixel.target_pixel) :
		(pixel.target_pixel - pixel.reference_pixel);
	assign sq       = SQ_W'(abs_diff) * SQ_W'(abs_diff);
	assign acc_next = acc_q + SUM_W'(sq);
	assign cnt_next = cnt_q + N_W'(1);
	assign done     = (cnt_next >= n_q);

	assign pixel.ready = push_ready;
	assign accept      = pixel.valid && pixel.ready;
	assign push_valid  = accept && done;
	assign push_data   = {acc_next, n_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (done) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_next;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

@@ hw/rtl/irpm_queue.sv @@
// short queue of finished image sums between front and back
module irpm_queue import irpm_pkg::*; #(
	parameter int W = 66
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]     slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow a lone push");

endmodule

@@ hw/rtl/irpm_back.sv @@
// back end: sequencer for division, square root, two log2 evaluations and psnr scaling
module irpm_back import irpm_pkg::*; #(
	parameter int N_W = 26
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [SUM_W+N_W-1:0] pop_data,
	irpm_result_if.source        result
);

	localparam int LX_W   = (PEAK_W + N_W > SUM_W) ? PEAK_W + N_W : SUM_W;
	localparam int EW     = $clog2(LX_W);
	localparam int LW     = EW + FRAC_W;
	localparam int PW     = LW + PSNR_SCALE_W;
	localparam int STEP_W = $clog2(QUO_W);
	localparam int ROOT_W = QUO_W / 2 + 1;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DIV      = 4'd1;
	localparam logic [3:0] ST_SQRT     = 4'd2;
	localparam logic [3:0] ST_RMSE     = 4'd3;
	localparam logic [3:0] ST_NORM     = 4'd4;
	localparam logic [3:0] ST_SQ_MUL   = 4'd5;
	localparam logic [3:0] ST_SQ_ADJ   = 4'd6;
	localparam logic [3:0] ST_LOG_DONE = 4'd7;
	localparam logic [3:0] ST_DIFF     = 4'd8;
	localparam logic [3:0] ST_PMUL     = 4'd9;
	localparam logic [3:0] ST_PRND     = 4'd10;
	localparam logic [3:0] ST_OUT      = 4'd11;

	logic [3:0]          state_q;
	logic [STEP_W-1:0]   step_q;
	logic [SUM_W-1:0]    s_q;
	logic [N_W-1:0]      n_q;
	logic [QUO_W-1:0]    dvd_q;
	logic [N_W-1:0]      rem_q;
	logic [QUO_W-1:0]    root_q;
	logic [QUO_W-1:0]    bit_q;
	logic [LX_W-1:0]     m_q;
	logic [EW-1:0]       e_q;
	logic [MANT_W-1:0]   mant_q;
	logic [2*MANT_W-1:0] prod_q;
	logic [FRAC_W-1:0]   frac_q;
	logic                sel_q;
	logic [LW-1:0]       la_q;
	logic [LW-1:0]       lb_q;
	logic [LW:0]         d_q;
	logic [PW-1:0]       pprod_q;
	logic [RMSE_W-1:0]   rmse_q;
	logic [PSNR_W-1:0]   psnr_q;
	logic                ident_q;

	logic                res_valid_q;
	logic [SUM_W-1:0]    res_sum_q;
	logic [RMSE_W-1:0]   res_rmse_q;
	logic [PSNR_W-1:0]   res_psnr_q;
	logic                res_ident_q;

	logic [SUM_W-1:0]    pop_sum;
	logic [N_W-1:0]      pop_n;
	logic [N_W:0]        rem_shift;
	logic [N_W:0]        rem_sub;
	logic                div_ge;
	logic [QUO_W-1:0]    trial;
	logic                sqrt_ge;
	logic [ROOT_W-1:0]   root_inc;
	logic [ROOT_W-2:0]   root_half;
	logic [MANT_W:0]     sq_top;
	logic [PW:0]         pround;
	logic [PW-PSNR_SHIFT:0] pshift;
	logic                res_load;

	assign pop_sum = pop_data[SUM_W+N_W-1:N_W];
	assign pop_n   = pop_data[N_W-1:0];

	// restoring division step, one quotient bit a cycle
	assign rem_shift = {rem_q, dvd_q[QUO_W-1]};
	assign div_ge    = (rem_shift >= {1'b0, n_q});
	assign rem_sub   = rem_shift - {1'b0, n_q};

	// bit-pair square root step
	assign trial     = root_q + bit_q;
	assign sqrt_ge   = (dvd_q >= trial);
	assign root_inc  = ROOT_W'(root_q[ROOT_W-2:0]) + ROOT_W'(1);
	assign root_half = root_inc[ROOT_W-1:1];

	// squared mantissa back in Q1.31 with one overflow bit
	assign sq_top = prod_q[2*MANT_W-1:MANT_W-1];

	assign pround = {1'b0, pprod_q} + ((PW+1)'(1) << (PSNR_SHIFT - 1));
	assign pshift = pround[PW:PSNR_SHIFT];

	assign pop_ready = (state_q == ST_IDLE);
	assign res_load  = (state_q == ST_OUT) && (!res_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			sel_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						state_q <= (pop_sum == '0) ? ST_OUT : ST_DIV;
						step_q  <= STEP_W'(QUO_W - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q <= ST_SQRT;
						step_q  <= STEP_W'(QUO_W / 2 - 1);
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_SQRT: begin
					if (step_q == '0) begin
						state_q <= ST_RMSE;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_RMSE: begin
					state_q <= ST_NORM;
					sel_q   <= 1'b0;
				end
				ST_NORM: begin
					if (m_q[LX_W-1]) begin
						state_q <= ST_SQ_MUL;
						step_q  <= STEP_W'(FRAC_W - 1);
					end
				end
				ST_SQ_MUL: begin
					state_q <= ST_SQ_ADJ;
				end
				ST_SQ_ADJ: begin
					if (step_q == '0) begin
						state_q <= ST_LOG_DONE;
					end else begin
						step_q  <= step_q - STEP_W'(1);
						state_q <= ST_SQ_MUL;
					end
				end
				ST_LOG_DONE: begin
					if (!sel_q) begin
						sel_q   <= 1'b1;
						state_q <= ST_NORM;
					end else begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_PMUL;
				end
				ST_PMUL: begin
					state_q <= (d_q[LW] || d_q == '0) ? ST_OUT : ST_PRND;
				end
				ST_PRND: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				s_q    <= pop_sum;
				n_q    <= pop_n;
				dvd_q  <= {pop_sum, {RMSE_SHIFT{1'b0}}};
				rem_q  <= '0;
				ident_q <= (pop_sum == '0);
				rmse_q <= '0;
				psnr_q <= PSNR_MAX;
			end
			ST_DIV: begin
				rem_q <= div_ge ? rem_sub[N_W-1:0] : rem_shift[N_W-1:0];
				dvd_q <= {dvd_q[QUO_W-2:0], div_ge};
				root_q <= '0;
				bit_q  <= {2'b01, {(QUO_W-2){1'b0}}};
			end
			ST_SQRT: begin
				if (sqrt_ge) begin
					dvd_q  <= dvd_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ST_RMSE: begin
				rmse_q <= (root_half > (ROOT_W-1)'(RMSE_MAX)) ? RMSE_MAX : root_half[RMSE_W-1:0];
				m_q    <= LX_W'(PEAK_SQUARED) * LX_W'(n_q);
				e_q    <= EW'(LX_W - 1);
			end
			ST_NORM: begin
				if (m_q[LX_W-1]) begin
					mant_q <= m_q[LX_W-1 -: MANT_W];
					frac_q <= '0;
				end else begin
					m_q <= m_q << 1;
					e_q <= e_q - EW'(1);
				end
			end
			ST_SQ_MUL: begin
				prod_q <= (2*MANT_W)'(mant_q) * (2*MANT_W)'(mant_q);
			end
			ST_SQ_ADJ: begin
				mant_q <= sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
				frac_q <= {frac_q[FRAC_W-2:0], sq_top[MANT_W]};
			end
			ST_LOG_DONE: begin
				if (!sel_q) begin
					la_q <= {e_q, frac_q};
					m_q  <= LX_W'(s_q);
					e_q  <= EW'(LX_W - 1);
				end else begin
					lb_q <= {e_q, frac_q};
				end
			end
			ST_DIFF: begin
				d_q <= {1'b0, la_q} - {1'b0, lb_q};
			end
			ST_PMUL: begin
				if (d_q[LW] || d_q == '0) begin
					psnr_q <= '0;
				end else begin
					pprod_q <= PW'(d_q[LW-1:0]) * PW'(PSNR_SCALE);
				end
			end
			ST_PRND: begin
				psnr_q <= (pshift > (PW-PSNR_SHIFT+1)'(PSNR_MAX)) ? PSNR_MAX :
					pshift[PSNR_W-1:0];
			end
			default: ;
		endcase
	end

	// output register, next image may be worked on while this waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_sum_q   <= s_q;
			res_rmse_q  <= rmse_q;
			res_psnr_q  <= psnr_q;
			res_ident_q <= ident_q;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.sum_squared_error = res_sum_q;
	assign result.rmse              = res_rmse_q;
	assign result.psnr              = res_psnr_q;
	assign result.images_identical  = res_ident_q;

	a_rem_below_n: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < n_q))
		else $error("division remainder not below pixel count");

	a_mant_normalized: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQ_ADJ) |-> (prod_q[2*MANT_W-1:2*MANT_W-2] != 2'b00))
		else $error("log2 mantissa lost normalization");

	a_identical_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_ident_q) |-> (res_psnr_q == PSNR_MAX && res_rmse_q == '0))
		else $error("identical images without saturated psnr and zero rmse");

endmodule

@@ hw/rtl/image_rmse_psnr_meter_unit.sv @@
// top level of the 8-bit image rmse and psnr meter
//
//  channel  dir  handshake        payload
//  pixel    in   valid / ready    reference_pixel, target_pixel
//  result   out  valid / ready    sum_squared_error, rmse, psnr, images_identical
//  cfg      in   cfg_we           cfg_index, cfg_data
//
// the front takes one pixel pair per cycle; an image sum goes into a two-entry queue
// the back works each image through 58 division steps, 29 root steps, two log2 runs of
// 2 to 41 normalize shifts plus 24 squarings each, and the psnr scaling; a zero sum goes
// straight to the output; pixels stall whenever two finished images wait in the queue
// reset clears control state at once, no clearing pass; config regs return to 256 x 256,
// or to MAX_DIMENSION square when that is smaller
module image_rmse_psnr_meter_unit import irpm_pkg::*; #(
	parameter int MAX_DIMENSION = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [DIM_CFG_W-1:0]   cfg_data,
	irpm_pixel_if.sink             pixel,
	irpm_result_if.source          result
);

	localparam int DIM_BITS = $clog2(MAX_DIMENSION + 1);
	localparam int DIM_W    = (DIM_BITS < DIM_CFG_W) ? DIM_BITS : DIM_CFG_W;
	localparam int N_W      = 2 * DIM_W;
	localparam int ENTRY_W  = SUM_W + N_W;

	logic               push_valid;
	logic               push_ready;
	logic [ENTRY_W-1:0] push_data;
	logic               pop_valid;
	logic               pop_ready;
	logic [ENTRY_W-1:0] pop_data;

	irpm_front #(
		.MAX_DIMENSION (MAX_DIMENSION),
		.DIM_W         (DIM_W),
		.N_W           (N_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel      (pixel),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	irpm_queue #(
		.W (ENTRY_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	irpm_back #(
		.N_W (N_W)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule
